>>> hdl/psabc_pkg.sv
// Package for the SYN/ARP/blacklist frame classifier.
// Holds the controller/datapath command and status types and the Host matcher.
// No dependencies.
`timescale 1ns / 1ps
package psabc_pkg;

    localparam int PAT_LEN = 22;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [5:0]  FLAGS_SYN  = 6'h02;
    localparam logic [15:0] PORT_RESET = 16'd80;

    // Blacklisted Host strings, first character in the top byte
    localparam logic [8*PAT_LEN-1:0] PAT_A = {"Host: www.goo", "gle.co.uk"};
    localparam logic [8*PAT_LEN-1:0] PAT_B = {"Host: www.face", "book.com"};

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;     // byte transfer
        logic eval;     // end of frame: latch results, bump counters
        logic rd;       // read table entry at search index
        logic step;     // advance search index
        logic insert;   // store the SYN source (or flag full)
    } t_dp_cmd;

    // Status from the datapath
    typedef struct packed {
        logic syn_now;  // finished frame is a pure SYN
        logic cnt_zero; // table empty
        logic hit;      // read entry equals SYN source
        logic idx_end;  // read entry was the last stored one
    } t_dp_sts;

    function automatic logic [7:0] pat_char(input logic [8*PAT_LEN-1:0] pat, input int idx);
        return pat[8*PAT_LEN-1-8*idx -: 8];
    endfunction

    // Longest pattern prefix that ends the matched text extended by c
    function automatic logic [4:0] match_next(input logic [8*PAT_LEN-1:0] pat,
                                              input logic [4:0] k_in,
                                              input logic [7:0] c);
        int  k;
        logic ok;
        logic found;
        logic [4:0] res;
        k = (k_in >= 5'(PAT_LEN)) ? 0 : int'(k_in);
        res = '0;
        found = 1'b0;
        if (pat_char(pat, k) == c) begin
            res = 5'(k + 1);
        end else begin
            for (int j = PAT_LEN - 1; j >= 1; j--) begin
                if (!found && j <= k) begin
                    ok = (pat_char(pat, j - 1) == c);
                    for (int i = 0; i < PAT_LEN - 1; i++) begin
                        if (i + 1 < j && pat_char(pat, i) != pat_char(pat, k - j + 1 + i))
                            ok = 1'b0;
                    end
                    if (ok) begin
                        res = 5'(j);
                        found = 1'b1;
                    end
                end
            end
        end
        return res;
    endfunction

endpackage

>>> hdl/psabc_ctrl.sv
// Controller state machine of the frame classifier.
// Depends on psabc_pkg for the command and status types.
`timescale 1ns / 1ps
module psabc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_last_byte,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output psabc_pkg::t_dp_cmd o_cmd,
    input  psabc_pkg::t_dp_sts i_sts
);
    import psabc_pkg::*;

    localparam logic [2:0] S_PARSE  = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_INSERT = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_PARSE;
        else          r_state <= n_state;
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_PARSE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_last_byte) n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (!i_sts.syn_now)      n_state = S_RESULT;
                else if (i_sts.cnt_zero) n_state = S_INSERT;
                else                     n_state = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CMP;
            end
            S_CMP: begin
                if (i_sts.hit)          n_state = S_RESULT;
                else if (i_sts.idx_end) n_state = S_INSERT;
                else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = S_RESULT;
            end
            S_RESULT: begin
                o_valid = 1'b1;
                if (i_ready) n_state = S_PARSE;
            end
            default: n_state = S_PARSE;
        endcase
    end
endmodule

>>> hdl/psabc_dp.sv
// Datapath of the frame classifier: header parse, Host matchers, source table, counters.
// Depends on psabc_pkg for types, constants and the matcher function.
`timescale 1ns / 1ps
module psabc_dp #(
    parameter int TABLE_DEPTH     = 256,
    parameter int MAX_FRAME_BYTES = 16384
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  psabc_pkg::t_dp_cmd i_cmd,
    output psabc_pkg::t_dp_sts o_sts,
    input  logic [15:0]       i_watched_port,
    input  logic [7:0]        i_frame_byte,
    output logic              o_syn_seen,
    output logic              o_new_source,
    output logic              o_table_full,
    output logic              o_arp_seen,
    output logic              o_first_host_hit,
    output logic              o_second_host_hit,
    output logic [31:0]       o_source_address,
    output logic [31:0]       o_dest_address,
    output logic [31:0]       o_syn_total,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] o_unique_total,
    output logic [31:0]       o_arp_total,
    output logic [31:0]       o_blacklist_total
);
    import psabc_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Frame state
    logic [15:0] r_pos;
    logic [15:0] r_etype;
    logic [7:0]  r_vihl, r_proto, r_doff, r_flags;
    logic [15:0] r_dport;
    logic [63:0] r_addr;
    logic [4:0]  r_ma, r_mb;
    logic [1:0]  r_hit;

    // Table and search
    logic [31:0]   r_mem [TABLE_DEPTH];
    logic [31:0]   r_rd_data;
    logic [31:0]   r_src;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;

    // Result registers
    logic r_syn_o, r_fresh, r_full, r_arp_o;
    logic [1:0]  r_hits_o;
    logic [31:0] r_src_o, r_dst_o, r_syn_tot, r_arp_tot, r_bl_tot;

    // Per-byte decode
    logic        hdr_ok, tcp_p, in_tcp, feed;
    logic [6:0]  t_off;
    logic [15:0] off;
    logic [3:0]  d_words;
    logic [4:0]  n_ma, n_mb;
    logic [1:0]  n_hit;

    assign hdr_ok = (r_etype == ETYPE_IPV4) && (r_vihl[7:4] == 4'd4) && (r_vihl[3:0] >= 4'd5);
    assign t_off  = 7'd14 + {1'b0, r_vihl[3:0], 2'b00};
    assign tcp_p  = (r_pos >= 16'd24) && hdr_ok && (r_proto == PROTO_TCP);
    assign in_tcp = tcp_p && (r_pos >= {9'd0, t_off});
    assign off    = r_pos - {9'd0, t_off};
    assign d_words = (r_doff[7:4] < 4'd5) ? 4'd5 : r_doff[7:4];
    assign feed   = in_tcp && (off >= 16'd20) && (off >= {10'd0, d_words, 2'b00})
                    && (r_dport == i_watched_port);

    // Matchers
    always_comb begin
        n_ma  = r_ma;
        n_mb  = r_mb;
        n_hit = r_hit;
        if (!r_hit[0]) begin
            n_ma = match_next(PAT_A, r_ma, i_frame_byte);
            if (n_ma >= 5'(PAT_LEN)) begin
                n_hit[0] = 1'b1;
                n_ma     = '0;
            end
        end
        if (!r_hit[1]) begin
            n_mb = match_next(PAT_B, r_mb, i_frame_byte);
            if (n_mb >= 5'(PAT_LEN)) begin
                n_hit[1] = 1'b1;
                n_mb     = '0;
            end
        end
    end

    // End-of-frame decode on the finished frame state
    logic        f_ipv4, f_tcp, f_syn, f_arp, f_watch;
    assign f_ipv4  = (r_pos >= 16'd15) && hdr_ok;
    assign f_tcp   = f_ipv4 && (r_pos >= 16'd24) && (r_proto == PROTO_TCP);
    assign f_syn   = f_tcp && (r_pos > {9'd0, t_off} + 16'd13) && (r_flags[5:0] == FLAGS_SYN);
    assign f_arp   = (r_pos >= 16'd14) && (r_etype == ETYPE_ARP);
    assign f_watch = f_tcp && (r_pos > {9'd0, t_off} + 16'd3) && (r_dport == i_watched_port);

    assign o_sts.syn_now  = f_syn;
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.hit      = (r_rd_data == r_src);
    assign o_sts.idx_end  = (r_idx + CW'(1) == r_cnt);

    // Frame parse registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.eval) begin
            r_pos   <= '0;
            r_etype <= '0;
            r_vihl  <= '0;
            r_proto <= '0;
            r_doff  <= '0;
            r_flags <= '0;
            r_dport <= '0;
            r_addr  <= '0;
            r_ma    <= '0;
            r_mb    <= '0;
            r_hit   <= '0;
        end else if (i_cmd.take && (r_pos < 16'(MAX_FRAME_BYTES))) begin
            r_pos <= r_pos + 16'd1;
            case (r_pos)
                16'd12:  r_etype[15:8] <= i_frame_byte;
                16'd13:  r_etype[7:0]  <= i_frame_byte;
                16'd14:  r_vihl        <= i_frame_byte;
                16'd23:  r_proto       <= i_frame_byte;
                default: ;
            endcase
            if (r_pos >= 16'd26 && r_pos <= 16'd33)
                r_addr[8*(7-int'(r_pos[2:0] - 3'd2)) +: 8] <= i_frame_byte;
            if (in_tcp) begin
                case (off)
                    16'd2:   r_dport[15:8] <= i_frame_byte;
                    16'd3:   r_dport[7:0]  <= i_frame_byte;
                    16'd12:  r_doff        <= i_frame_byte;
                    16'd13:  r_flags       <= i_frame_byte;
                    default: ;
                endcase
            end
            if (feed) begin
                r_ma  <= n_ma;
                r_mb  <= n_mb;
                r_hit <= n_hit;
            end
        end
    end

    // Source table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && (r_cnt < CW'(TABLE_DEPTH)))
            r_mem[r_cnt[AW-1:0]] <= r_src;
        if (i_cmd.rd)
            r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    // Search index, table fill, counters and results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_idx     <= '0;
            r_syn_tot <= '0;
            r_arp_tot <= '0;
            r_bl_tot  <= '0;
            r_syn_o   <= 1'b0;
            r_fresh   <= 1'b0;
            r_full    <= 1'b0;
            r_arp_o   <= 1'b0;
            r_hits_o  <= '0;
            r_src_o   <= '0;
            r_dst_o   <= '0;
            r_src     <= '0;
        end else begin
            if (i_cmd.eval) begin
                r_idx    <= '0;
                r_src    <= r_addr[63:32];
                r_syn_o  <= f_syn;
                r_arp_o  <= f_arp;
                r_fresh  <= 1'b0;
                r_full   <= 1'b0;
                r_hits_o <= f_watch ? r_hit : 2'b00;
                r_src_o  <= f_ipv4 ? r_addr[63:32] : 32'd0;
                r_dst_o  <= f_ipv4 ? r_addr[31:0] : 32'd0;
                if (f_syn)                  r_syn_tot <= r_syn_tot + 32'd1;
                if (f_arp)                  r_arp_tot <= r_arp_tot + 32'd1;
                if (f_watch && r_hit != '0) r_bl_tot  <= r_bl_tot + 32'd1;
            end
            if (i_cmd.step) r_idx <= r_idx + CW'(1);
            if (i_cmd.insert) begin
                if (r_cnt < CW'(TABLE_DEPTH)) begin
                    r_cnt   <= r_cnt + CW'(1);
                    r_fresh <= 1'b1;
                end else begin
                    r_full  <= 1'b1;
                end
            end
        end
    end

    assign o_syn_seen        = r_syn_o;
    assign o_new_source      = r_fresh;
    assign o_table_full      = r_full;
    assign o_arp_seen        = r_arp_o;
    assign o_first_host_hit  = r_hits_o[0];
    assign o_second_host_hit = r_hits_o[1];
    assign o_source_address  = r_src_o;
    assign o_dest_address    = r_dst_o;
    assign o_syn_total       = r_syn_tot;
    assign o_unique_total    = r_cnt;
    assign o_arp_total       = r_arp_tot;
    assign o_blacklist_total = r_bl_tot;
endmodule

>>> hdl/packet_syn_arp_blacklist_classifier_unit.sv
// Frame classifier: takes an Ethernet frame one byte per transfer and, after the last
// byte, gives one result (ARP, pure SYN, new SYN source, table full, Host blacklist hits,
// IPv4 addresses and running counts). Bytes are taken at one per cycle while a frame is
// being parsed; o_ready is low from the last byte until the result transfer completes.
// After the last byte the block evaluates the frame; for a SYN frame it then scans the
// source table entry by entry (memory read, then compare) until a hit or the last stored
// entry, and on no hit stores the new source. The result register holds until its
// transfer completes, and the next frame's first byte is taken in the cycle after that.
// Depends on psabc_pkg, psabc_ctrl and psabc_dp.
`timescale 1ns / 1ps
module packet_syn_arp_blacklist_classifier_unit #(
    parameter int TABLE_DEPTH     = 256,
    parameter int MAX_FRAME_BYTES = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_syn_seen,
    output logic        o_new_source,
    output logic        o_table_full,
    output logic        o_arp_seen,
    output logic        o_first_host_hit,
    output logic        o_second_host_hit,
    output logic [31:0] o_source_address,
    output logic [31:0] o_dest_address,
    output logic [31:0] o_syn_total,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] o_unique_total,
    output logic [31:0] o_arp_total,
    output logic [31:0] o_blacklist_total
);
    import psabc_pkg::*;

    t_dp_cmd     cmd;
    t_dp_sts     sts;
    logic [15:0] r_watched_port;

    // Watched port register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)         r_watched_port <= PORT_RESET;
        else if (i_cfg_wr_en) r_watched_port <= i_cfg_wr_data;
    end

    psabc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last_byte (i_last_byte),
        .o_ready     (o_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    psabc_dp #(
        .TABLE_DEPTH     (TABLE_DEPTH),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_watched_port    (r_watched_port),
        .i_frame_byte      (i_frame_byte),
        .o_syn_seen        (o_syn_seen),
        .o_new_source      (o_new_source),
        .o_table_full      (o_table_full),
        .o_arp_seen        (o_arp_seen),
        .o_first_host_hit  (o_first_host_hit),
        .o_second_host_hit (o_second_host_hit),
        .o_source_address  (o_source_address),
        .o_dest_address    (o_dest_address),
        .o_syn_total       (o_syn_total),
        .o_unique_total    (o_unique_total),
        .o_arp_total       (o_arp_total),
        .o_blacklist_total (o_blacklist_total)
    );
endmodule
